/* hw/rtl/pngu_pkg.sv */
// Shared constants, types and codes for the PNG scanline unfilter.
`default_nettype none
package pngu_pkg;

  localparam int ROW_MAX   = 8192;
  localparam int BPP_MAX   = 8;
  localparam int COL_W     = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int BPP_SEL_W = (BPP_MAX > 1) ? $clog2(BPP_MAX) : 1;
  localparam int HIST_W    = 8 * BPP_MAX;

  localparam int BPP_W  = 4;
  localparam int ROWB_W = 14;
  localparam int ROWS_W = 16;
  localparam int CFG_W  = 16;

  typedef enum logic [1:0] {
    REG_BPP       = 2'd0,
    REG_ROW_BYTES = 2'd1,
    REG_IMG_ROWS  = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filter_t;

  // one request in the reconstruct stage
  typedef struct packed {
    logic             is_data;
    logic [7:0]       x;
    logic [COL_W-1:0] col;
    logic             row_zero;
    filter_t          filter;
    logic             row_end;
    logic             image_end;
  } stage_t;

endpackage
`default_nettype wire

/* hw/rtl/png_scanline_unfilter_unit.sv */
// Top level of the PNG scanline unfilter: row tracking, line store, output register.
// One filtered byte is accepted per clock and one reconstructed byte leaves per clock
// while out_ready holds; the filter type byte at each row start is consumed and gives no output.
// The line store (one synchronous RAM of ROW_MAX bytes holding the previous row) is read
// when a byte is accepted into the stage register s1 and written back with the reconstructed
// byte when s1 fires, followed by a registered output with handshake.
// The line store has no clearing pass; the first row of each image uses zero as its
// up neighbor. Registers: 0 bytes per pixel, 1 row bytes, 2 image rows.
`default_nettype none
module png_scanline_unfilter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  stream_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       pixel_byte,
  output logic             row_end,
  output logic             image_end,
  output logic             bad_filter
);

  localparam int COL_W = pngu_pkg::COL_W;

  logic [pngu_pkg::BPP_W-1:0]  bytes_per_pixel;
  logic [pngu_pkg::ROWB_W-1:0] row_bytes;
  logic [pngu_pkg::ROWS_W-1:0] image_rows;

  logic                        awaiting;
  logic [COL_W-1:0]            column_count;
  logic [pngu_pkg::ROWS_W-1:0] row_count;
  logic [7:0]                  row_filter;

  logic [7:0] line_store [pngu_pkg::ROW_MAX];
  logic [7:0] rdata;

  pngu_pkg::stage_t s1;
  pngu_pkg::stage_t s1_next;
  logic             s1_valid;
  logic             s1_fire;
  logic             accept;

  logic [pngu_pkg::HIST_W-1:0]    left_hist;
  logic [pngu_pkg::HIST_W-1:0]    upleft_hist;
  logic [pngu_pkg::BPP_SEL_W-1:0] bpp_sel;
  logic [pngu_pkg::ROWB_W-1:0]    len_eff;
  logic [pngu_pkg::ROWS_W-1:0]    rows_eff;
  logic [pngu_pkg::ROWB_W:0]      col_plus;
  logic [pngu_pkg::ROWS_W:0]      row_plus;
  logic                           rend;
  logic                           iend;
  logic [7:0]                     up;
  logic [7:0]                     pix;
  pngu_pkg::filter_t              filt_code;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= 4'd4;
      row_bytes       <= 14'd4096;
      image_rows      <= 16'd1024;
    end else if (cfg_write) begin
      case (pngu_pkg::cfg_reg_t'(cfg_index))
        pngu_pkg::REG_BPP:       bytes_per_pixel <= cfg_data[pngu_pkg::BPP_W-1:0];
        pngu_pkg::REG_ROW_BYTES: row_bytes       <= cfg_data[pngu_pkg::ROWB_W-1:0];
        pngu_pkg::REG_IMG_ROWS:  image_rows      <= cfg_data[pngu_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bytes_per_pixel == '0) begin
      bpp_sel = '0;
    end else if (32'(bytes_per_pixel) > pngu_pkg::BPP_MAX) begin
      bpp_sel = pngu_pkg::BPP_SEL_W'(pngu_pkg::BPP_MAX - 1);
    end else begin
      bpp_sel = pngu_pkg::BPP_SEL_W'(bytes_per_pixel - 4'd1);
    end
    if (row_bytes == '0) begin
      len_eff = pngu_pkg::ROWB_W'(1);
    end else if (32'(row_bytes) > pngu_pkg::ROW_MAX) begin
      len_eff = pngu_pkg::ROWB_W'(pngu_pkg::ROW_MAX);
    end else begin
      len_eff = row_bytes;
    end
    rows_eff = (image_rows == '0) ? pngu_pkg::ROWS_W'(1) : image_rows;
    col_plus = (pngu_pkg::ROWB_W + 1)'(column_count) + 1'b1;
    row_plus = (pngu_pkg::ROWS_W + 1)'(row_count) + 1'b1;
    rend = col_plus >= {1'b0, len_eff};
    iend = rend && (row_plus >= {1'b0, rows_eff});
    filt_code = (row_filter > 8'd4) ? pngu_pkg::FILT_BAD
                                    : pngu_pkg::filter_t'(row_filter[2:0]);
  end

  assign s1_fire  = s1_valid && (!s1.is_data || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign accept   = in_valid && in_ready;

  always_comb begin
    s1_next.is_data   = !awaiting;
    s1_next.x         = stream_byte;
    s1_next.col       = column_count;
    s1_next.row_zero  = (row_count == '0);
    s1_next.filter    = filt_code;
    s1_next.row_end   = rend;
    s1_next.image_end = iend;
  end

  // row and column tracking at accept
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting     <= 1'b1;
      column_count <= '0;
      row_count    <= '0;
      row_filter   <= 8'd0;
    end else if (accept) begin
      if (awaiting) begin
        row_filter   <= stream_byte;
        column_count <= '0;
        awaiting     <= 1'b0;
      end else if (rend) begin
        awaiting     <= 1'b1;
        column_count <= '0;
        row_count    <= iend ? '0 : row_plus[pngu_pkg::ROWS_W-1:0];
      end else begin
        column_count <= col_plus[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // line store: read at accept, write back when the byte is reconstructed
  always_ff @(posedge clk) begin
    if (accept && !awaiting) begin
      rdata <= line_store[column_count];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1.is_data) begin
      line_store[s1.col] <= pix;
    end
  end

  assign up = s1.row_zero ? 8'd0 : rdata;

  pngu_predict u_predict (
    .filter      (s1.filter),
    .x           (s1.x),
    .left_hist   (left_hist),
    .upleft_hist (upleft_hist),
    .bpp_sel     (bpp_sel),
    .up          (up),
    .pix         (pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_hist   <= '0;
      upleft_hist <= '0;
    end else if (s1_fire) begin
      if (s1.is_data) begin
        left_hist   <= {left_hist[pngu_pkg::HIST_W-9:0], pix};
        upleft_hist <= {upleft_hist[pngu_pkg::HIST_W-9:0], up};
      end else begin
        left_hist   <= '0;
        upleft_hist <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1.is_data) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1.is_data) begin
      pixel_byte <= pix;
      row_end    <= s1.row_end;
      image_end  <= s1.image_end;
      bad_filter <= (s1.filter == pngu_pkg::FILT_BAD);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pngu_predict.sv */
// Predictor selection and byte reconstruction (none, sub, up, average, Paeth).
`default_nettype none
module pngu_predict (
  input  wire pngu_pkg::filter_t              filter,
  input  wire logic [7:0]                     x,
  input  wire logic [pngu_pkg::HIST_W-1:0]    left_hist,
  input  wire logic [pngu_pkg::HIST_W-1:0]    upleft_hist,
  input  wire logic [pngu_pkg::BPP_SEL_W-1:0] bpp_sel,
  input  wire logic [7:0]                     up,
  output logic [7:0]                          pix
);

  logic [7:0] a;
  logic [7:0] c;
  logic [7:0] pred;
  logic [8:0] sum_ab;
  logic signed [10:0] p;
  logic signed [10:0] da;
  logic signed [10:0] db;
  logic signed [10:0] dc;
  logic [10:0] pa;
  logic [10:0] pb;
  logic [10:0] pc;
  logic [7:0] paeth;

  always_comb begin
    a = left_hist[{bpp_sel, 3'b000} +: 8];
    c = upleft_hist[{bpp_sel, 3'b000} +: 8];
    sum_ab = {1'b0, a} + {1'b0, up};
    p  = $signed({3'b000, a}) + $signed({3'b000, up}) - $signed({3'b000, c});
    da = p - $signed({3'b000, a});
    db = p - $signed({3'b000, up});
    dc = p - $signed({3'b000, c});
    pa = da[10] ? 11'(-da) : 11'(da);
    pb = db[10] ? 11'(-db) : 11'(db);
    pc = dc[10] ? 11'(-dc) : 11'(dc);
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = up;
    end else begin
      paeth = c;
    end
    case (filter)
      pngu_pkg::FILT_NONE:  pred = 8'd0;
      pngu_pkg::FILT_SUB:   pred = a;
      pngu_pkg::FILT_UP:    pred = up;
      pngu_pkg::FILT_AVG:   pred = sum_ab[8:1];
      pngu_pkg::FILT_PAETH: pred = paeth;
      default:              pred = 8'd0;
    endcase
    pix = x + pred;
  end

endmodule
`default_nettype wire

/* tb/png_unfilter_scoreboard.sv */
`timescale 1ns / 100ps
// Scoreboard for the PNG scanline unfilter: predicts each reconstructed byte and checks it.
module png_unfilter_scoreboard (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  stream_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [7:0]  pixel_byte,
  input  wire logic        row_end,
  input  wire logic        image_end,
  input  wire logic        bad_filter,
  output int               errors,
  output int               outstanding
);

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
    logic       bad;
  } pixel_rec_t;

  pixel_rec_t                  expected_pixels[$];
  logic [7:0]                  prev_row [pngu_pkg::ROW_MAX];
  logic [pngu_pkg::HIST_W-1:0] left_hist;
  logic [pngu_pkg::HIST_W-1:0] upleft_hist;
  int unsigned                 col_pos;
  int unsigned                 row_pos;
  logic [7:0]                  row_filter;
  logic                        awaiting_filter;
  logic [pngu_pkg::BPP_W-1:0]  reg_bpp;
  logic [pngu_pkg::ROWB_W-1:0] reg_len;
  logic [pngu_pkg::ROWS_W-1:0] reg_rows;
  int                          mismatches = 0;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int p;
    int pa;
    int pb;
    int pc;
    p  = int'(a) + int'(b) - int'(c);
    pa = p - int'(a);
    pb = p - int'(b);
    pc = p - int'(c);
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  task automatic unfilter_byte(input logic [7:0] x);
    int unsigned       bpp;
    int unsigned       len;
    int unsigned       rows;
    int unsigned       col;
    logic [7:0]        a;
    logic [7:0]        b;
    logic [7:0]        c;
    logic [7:0]        pred;
    logic [8:0]        sum;
    pngu_pkg::filter_t kind;
    pixel_rec_t        rec;
    if (awaiting_filter) begin
      row_filter      = x;
      left_hist       = '0;
      upleft_hist     = '0;
      col_pos         = 0;
      awaiting_filter = 1'b0;
      return;
    end
    bpp  = (reg_bpp == 0) ? 1 : (reg_bpp > pngu_pkg::BPP_MAX) ? pngu_pkg::BPP_MAX : reg_bpp;
    len  = (reg_len == 0) ? 1 : (reg_len > pngu_pkg::ROW_MAX) ? pngu_pkg::ROW_MAX : reg_len;
    rows = (reg_rows == 0) ? 1 : reg_rows;
    col  = (col_pos >= pngu_pkg::ROW_MAX) ? pngu_pkg::ROW_MAX - 1 : col_pos;

    a = left_hist[8*(bpp-1) +: 8];
    b = (row_pos > 0) ? prev_row[col] : 8'h00;
    c = upleft_hist[8*(bpp-1) +: 8];
    kind = (row_filter > 8'd4) ? pngu_pkg::FILT_BAD : pngu_pkg::filter_t'(row_filter[2:0]);
    sum  = {1'b0, a} + {1'b0, b};
    case (kind)
      pngu_pkg::FILT_NONE:  pred = 8'h00;
      pngu_pkg::FILT_SUB:   pred = a;
      pngu_pkg::FILT_UP:    pred = b;
      pngu_pkg::FILT_AVG:   pred = sum[8:1];
      pngu_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
      default:              pred = 8'h00;
    endcase

    rec.pixel     = x + pred;
    rec.bad       = (kind == pngu_pkg::FILT_BAD);
    rec.row_end   = (col_pos + 1 >= len);
    rec.image_end = rec.row_end && (row_pos + 1 >= rows);

    prev_row[col] = rec.pixel;
    left_hist     = {left_hist[pngu_pkg::HIST_W-9:0], rec.pixel};
    upleft_hist   = {upleft_hist[pngu_pkg::HIST_W-9:0], b};

    if (rec.row_end) begin
      awaiting_filter = 1'b1;
      col_pos         = 0;
      row_pos         = rec.image_end ? 0 : ((row_pos + 1) & 32'hFFFF);
    end else begin
      col_pos++;
    end
    expected_pixels.push_back(rec);
  endtask

  always @(posedge clk) begin : watch
    pixel_rec_t got;
    pixel_rec_t want;
    if (rst) begin
      expected_pixels.delete();
      left_hist       = '0;
      upleft_hist     = '0;
      col_pos         = 0;
      row_pos         = 0;
      row_filter      = 8'h00;
      awaiting_filter = 1'b1;
      reg_bpp         = 4'd4;
      reg_len         = 14'd4096;
      reg_rows        = 16'd1024;
    end else begin
      if (in_valid && in_ready) unfilter_byte(stream_byte);
      if (cfg_write) begin
        case (pngu_pkg::cfg_reg_t'(cfg_index))
          pngu_pkg::REG_BPP:       reg_bpp  = cfg_data[pngu_pkg::BPP_W-1:0];
          pngu_pkg::REG_ROW_BYTES: reg_len  = cfg_data[pngu_pkg::ROWB_W-1:0];
          pngu_pkg::REG_IMG_ROWS:  reg_rows = cfg_data[pngu_pkg::ROWS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{pixel_byte, row_end, image_end, bad_filter};
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result pixel %02h row_end %0b image_end %0b bad %0b",
                     $realtime, got.pixel, got.row_end, got.image_end, got.bad);
        end else begin
          want = expected_pixels.pop_front();
          if (got.pixel !== want.pixel || got.row_end !== want.row_end ||
              got.image_end !== want.image_end || got.bad !== want.bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: exp/act pixel %02h/%02h re %0b/%0b ie %0b/%0b bad %0b/%0b",
                       $realtime, want.pixel, got.pixel, want.row_end, got.row_end,
                       want.image_end, got.image_end, want.bad, got.bad);
          end
        end
      end
    end
    errors      <= mismatches;
    outstanding <= expected_pixels.size();
  end

endmodule

/* tb/png_scanline_unfilter_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench top for png_scanline_unfilter_unit: drives filtered rows and gives the verdict.
module png_scanline_unfilter_unit_tb;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_REQS = 1000;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_write   = 1'b0;
  logic [1:0]  cfg_index   = pngu_pkg::REG_BPP;
  logic [15:0] cfg_data    = 16'h0000;
  logic        in_valid    = 1'b0;
  logic [7:0]  stream_byte = 8'h00;
  logic        out_ready   = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  pixel_byte;
  logic        row_end;
  logic        image_end;
  logic        bad_filter;

  int          errors;
  int          outstanding;
  int          quiet_cycles = 0;
  logic        steady       = 1'b0;
  logic        hold_req     = 1'b0;

  // request framing as the sender sees it
  logic        trk_await = 1'b1;
  int unsigned trk_col   = 0;
  int unsigned trk_row   = 0;
  int unsigned eff_len   = 4096;
  int unsigned eff_rows  = 1024;
  logic [15:0] raw_len   = 16'd4096;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  png_scanline_unfilter_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .stream_byte(stream_byte),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_byte(pixel_byte),
    .row_end(row_end), .image_end(image_end), .bad_filter(bad_filter)
  );

  png_unfilter_scoreboard scoreboard (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .stream_byte(stream_byte),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_byte(pixel_byte),
    .row_end(row_end), .image_end(image_end), .bad_filter(bad_filter),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin : receiver
    int   hold_left;
    logic held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_req(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (trk_await) begin
      trk_await = 1'b0;
      trk_col   = 0;
    end else if (trk_col + 1 >= eff_len) begin
      trk_await = 1'b1;
      trk_col   = 0;
      trk_row   = (trk_row + 1 >= eff_rows) ? 0 : ((trk_row + 1) & 32'hFFFF);
    end else begin
      trk_col++;
    end
  endtask

  // mostly valid filter types at row starts, random data elsewhere
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (trk_await) return (r < 85) ? 8'($urandom_range(4)) : 8'($urandom_range(255));
    if (r < 5) return 8'h00;
    if (r < 10) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // row_bytes may only change on the first row of an image
  task automatic program_regs(input logic [15:0] bpp, input logic [15:0] len,
                              input logic [15:0] rows);
    cfg_write <= 1'b1;
    cfg_index <= pngu_pkg::REG_BPP;
    cfg_data  <= bpp;
    @(posedge clk);
    cfg_index <= pngu_pkg::REG_ROW_BYTES;
    cfg_data  <= len;
    @(posedge clk);
    cfg_index <= pngu_pkg::REG_IMG_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_write <= 1'b0;
    raw_len  = len;
    eff_len  = (len[13:0] == 0) ? 1
             : (len[13:0] > pngu_pkg::ROW_MAX) ? pngu_pkg::ROW_MAX : len[13:0];
    eff_rows = (rows == 0) ? 1 : rows;
  endtask

  initial begin : stimulus
    logic [7:0]  row_types [7];
    logic [7:0]  row_data [14];
    int          sent;
    int          phase;
    int          n;
    int          r;
    logic [15:0] bpp_v;
    logic [15:0] len_v;
    logic [15:0] rows_v;

    row_types = '{8'(pngu_pkg::FILT_UP), 8'(pngu_pkg::FILT_AVG), 8'(pngu_pkg::FILT_PAETH),
                  8'd5, 8'(pngu_pkg::FILT_NONE), 8'hFF, 8'(pngu_pkg::FILT_SUB)};
    row_data  = '{8'hFF, 8'h00, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'hFE, 8'h01,
                  8'h00, 8'h00, 8'hFF, 8'hFF, 8'h55, 8'hAA};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: sub filter at four bytes per pixel
    push_req(8'(pngu_pkg::FILT_SUB));
    push_req(8'h00);
    push_req(8'hFF);
    push_req(8'h80);
    push_req(8'h01);
    push_req(8'h7F);
    // shrink the row mid-row; the next byte ends it
    drain();
    program_regs(16'd1, 16'd2, 16'd2);
    push_req(8'h10);
    for (int i = 0; i < 7; i++) begin
      push_req(row_types[i]);
      push_req(row_data[2*i]);
      push_req(row_data[2*i+1]);
    end

    // widest rows, widest pixel, register bits above the field width
    drain();
    program_regs(16'd8, 16'd8192, 16'd2);
    push_req(8'(pngu_pkg::FILT_PAETH));
    repeat (100) push_req(pick_byte());
    drain();
    program_regs(16'hABC8, 16'hFFFF, 16'd2);
    repeat (20) push_req(pick_byte());
    // cut the first row short, then a second row over the stored bytes
    drain();
    program_regs(16'd8, 16'd48, 16'd2);
    do push_req(pick_byte()); while (!(trk_await && trk_row == 0));

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_REQS) begin
      phase++;
      drain();
      r = $urandom_range(9);
      bpp_v = (r < 8) ? 16'($urandom_range(1, 8)) : (r == 8) ? 16'd0
                      : 16'($urandom_range(9, 15));
      bpp_v[15:4] = 12'($urandom);
      r = $urandom_range(19);
      len_v = (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom_range(65, 300))
                       : 16'($urandom_range(1, 24));
      len_v[15:14] = 2'($urandom);
      r = $urandom_range(19);
      rows_v = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF
                        : (r == 2) ? 16'($urandom_range(5, 40)) : 16'($urandom_range(1, 4));
      case (phase)
        1: begin
          bpp_v  = 16'd0;
          len_v  = 16'd0;
          rows_v = 16'd0;
        end
        2: begin
          bpp_v  = 16'd15;
          len_v  = 16'd1;
          rows_v = 16'hFFFF;
        end
        default: ;
      endcase
      if (trk_row != 0) len_v = raw_len;
      program_regs(bpp_v, len_v, rows_v);

      n = $urandom_range(20, 150);
      steady <= (phase == 4);
      if (phase == 4) n = 250;
      if (phase == 6) begin
        hold_req <= 1'b1;
        n = 150;
      end
      for (int i = 0; i < n; i++) begin
        push_req(pick_byte());
        if (phase == 8 && i == n / 2) drain();
      end
      sent += n;
    end
    steady <= 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pngu_pkg.sv
hw/rtl/pngu_predict.sv
hw/rtl/png_scanline_unfilter_unit.sv
tb/png_unfilter_scoreboard.sv
tb/png_scanline_unfilter_unit_tb.sv
